FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame parser.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SLFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define SLFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/slfp_pkg.sv
// Package for the sync/length frame parser: parse phases, function codes,
// register indexes and reset values. No dependencies.
package slfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int PAYLOAD_W       = 64;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'h55;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 4'd9;

    localparam logic [BYTE_W-1:0] FN_01 = 8'h01;
    localparam logic [BYTE_W-1:0] FN_03 = 8'h03;
    localparam logic [BYTE_W-1:0] FN_05 = 8'h05;
    localparam logic [BYTE_W-1:0] FN_07 = 8'h07;
    localparam logic [BYTE_W-1:0] FN_11 = 8'h11;
    localparam logic [BYTE_W-1:0] FN_13 = 8'h13;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    function automatic logic known_function(input logic [BYTE_W-1:0] f);
        return f == FN_01 || f == FN_03 || f == FN_05 || f == FN_07 ||
               f == FN_11 || f == FN_13;
    endfunction

endpackage

FILE: hw/rtl/sync_length_frame_parser_top.sv
// Sync/length framed packet parser with a check against the inverted 8-bit sum.
// Depends on slfp_pkg and assert_macros.svh.
//
// Usage:
//   Receive channel: one byte per transfer on i_rx_byte (i_rx_valid / o_rx_stall).
//   Result channel: one frame per transfer (o_res_valid / i_res_stall) carrying
//   function code, payload length, zero-padded payload and checksum flag.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 first sync byte, 1 second sync byte, 2 length limit); write only when idle.
//   Throughput: one byte per cycle while o_rx_stall is low. The phase machine,
//   running sum and payload store all update in the cycle the byte is taken.
//   Result: the frame result is in the output register in the cycle after the
//   checksum byte transfer.
//   Stall: while a result waits under i_res_stall, bytes keep flowing; only a
//   checksum byte is held off (o_rx_stall high in the checksum phase).
//   Reset: i_rst_n low (synchronous) restores register defaults, empties the
//   output register and returns the parser to hunting for the first sync byte.
`include "assert_macros.svh"

module sync_length_frame_parser_top #(
    parameter int MAX_PAYLOAD = slfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [slfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slfp_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                               i_rx_valid,
    output logic                               o_rx_stall,
    input  logic [slfp_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output logic [slfp_pkg::BYTE_W-1:0]        o_function_code,
    output logic [slfp_pkg::LEN_W-1:0]         o_payload_length,
    output logic [slfp_pkg::PAYLOAD_W-1:0]     o_payload_bytes,
    output logic                               o_checksum_ok
);

    localparam int STORE_W = slfp_pkg::BYTE_W * MAX_PAYLOAD;
    localparam logic [slfp_pkg::LEN_W-1:0] LIMIT_CAP = slfp_pkg::LEN_W'(MAX_PAYLOAD + 1);

    logic [slfp_pkg::BYTE_W-1:0] r_sync_first, r_sync_second;
    logic [slfp_pkg::LEN_W-1:0]  r_length_limit;

    slfp_pkg::t_phase            r_phase, n_phase;
    logic [slfp_pkg::BYTE_W-1:0] r_func, n_func;
    logic [slfp_pkg::LEN_W-1:0]  r_len, n_len;
    logic [slfp_pkg::LEN_W-1:0]  r_count, n_count;
    logic [slfp_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [STORE_W-1:0]          r_store, n_store;

    logic                          r_out_valid, n_out_valid;
    logic [slfp_pkg::BYTE_W-1:0]   r_out_func;
    logic [slfp_pkg::LEN_W-1:0]    r_out_len;
    logic [slfp_pkg::PAYLOAD_W-1:0] r_out_payload, n_padded;
    logic                          r_out_ok;

    logic                          rx_take, res_take, load;
    logic [slfp_pkg::LEN_W-1:0]    eff_limit;
    logic [slfp_pkg::BYTE_W-1:0]   b;

    assign b          = i_rx_byte;
    assign o_rx_stall = r_out_valid && i_res_stall && (r_phase == slfp_pkg::PH_CHECK);
    assign rx_take    = i_rx_valid && !o_rx_stall;
    assign res_take   = r_out_valid && !i_res_stall;
    assign load       = rx_take && (r_phase == slfp_pkg::PH_CHECK);
    assign eff_limit  = (r_length_limit > LIMIT_CAP) ? LIMIT_CAP : r_length_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first   <= slfp_pkg::SYNC_FIRST_RST;
            r_sync_second  <= slfp_pkg::SYNC_SECOND_RST;
            r_length_limit <= slfp_pkg::LENGTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slfp_pkg::CFG_SYNC_FIRST:   r_sync_first   <= i_cfg_data;
                slfp_pkg::CFG_SYNC_SECOND:  r_sync_second  <= i_cfg_data;
                slfp_pkg::CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data[slfp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= slfp_pkg::PH_SYNC1;
            r_func      <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_store     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_func      <= n_func;
            r_len       <= n_len;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_store     <= n_store;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_func    <= r_func;
            r_out_len     <= r_len;
            r_out_payload <= n_padded;
            r_out_ok      <= (~r_sum == b);
        end
    end

    always_comb begin
        n_padded                = '0;
        n_padded[STORE_W-1:0]   = r_store;
    end

    always_comb begin
        n_phase     = r_phase;
        n_func      = r_func;
        n_len       = r_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_store     = r_store;
        n_out_valid = load || (r_out_valid && !res_take);
        if (rx_take) begin
            case (r_phase)
                slfp_pkg::PH_SYNC1: begin
                    n_phase = (b == r_sync_first) ? slfp_pkg::PH_SYNC2 : slfp_pkg::PH_SYNC1;
                end
                slfp_pkg::PH_SYNC2: begin
                    n_phase = (b == r_sync_second) ? slfp_pkg::PH_FUNC : slfp_pkg::PH_SYNC1;
                end
                slfp_pkg::PH_FUNC: begin
                    if (slfp_pkg::known_function(b)) begin
                        n_func  = b;
                        n_sum   = b;
                        n_phase = slfp_pkg::PH_LEN;
                    end else begin
                        n_phase = slfp_pkg::PH_SYNC1;
                    end
                end
                slfp_pkg::PH_LEN: begin
                    if (b >= slfp_pkg::BYTE_W'(eff_limit)) begin
                        // rejected length byte may itself open a frame
                        n_phase = (b == r_sync_first) ? slfp_pkg::PH_SYNC2
                                                      : slfp_pkg::PH_SYNC1;
                    end else begin
                        n_len   = b[slfp_pkg::LEN_W-1:0];
                        n_sum   = r_sum + b;
                        n_count = '0;
                        n_phase = (b == '0) ? slfp_pkg::PH_CHECK : slfp_pkg::PH_DATA;
                    end
                end
                slfp_pkg::PH_DATA: begin
                    for (int i = 0; i < MAX_PAYLOAD; i++) begin
                        if (r_count == slfp_pkg::LEN_W'(i)) begin
                            n_store[slfp_pkg::BYTE_W*i +: slfp_pkg::BYTE_W] = b;
                        end
                    end
                    n_sum   = r_sum + b;
                    n_count = r_count + 1'b1;
                    if (n_count >= r_len) begin
                        n_phase = slfp_pkg::PH_CHECK;
                    end
                end
                slfp_pkg::PH_CHECK: begin
                    n_func  = '0;
                    n_len   = '0;
                    n_count = '0;
                    n_sum   = '0;
                    n_store = '0;
                    n_phase = slfp_pkg::PH_SYNC1;
                end
                default: begin
                    n_phase = slfp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_function_code  = r_out_func;
    assign o_payload_length = r_out_len;
    assign o_payload_bytes  = r_out_payload;
    assign o_checksum_ok    = r_out_ok;

    // data phase always has bytes still to come
    `SLFP_ASSERT_NOW(a_data_pending, i_clk, i_rst_n,
        r_phase == slfp_pkg::PH_DATA, r_len != '0 && r_count < r_len)

    // checksum transfer loads a result and clears the frame state
    `SLFP_ASSERT_NXT(a_check_clears, i_clk, i_rst_n,
        rx_take && r_phase == slfp_pkg::PH_CHECK,
        r_out_valid && r_phase == slfp_pkg::PH_SYNC1 && r_sum == '0 && r_store == '0)

    // payload bytes beyond the reported length are zero
    `SLFP_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n,
        o_res_valid, (o_payload_bytes >> (8 * o_payload_length)) == '0)

endmodule
